[src/dmt_pkg.sv]
`timescale 1ns / 1ps
// Package for the disciplined millisecond tick generator.
// Holds shared types, constants and the period clamp; no dependencies.
package dmt_pkg;

  // Internal period width covers nominal + 1/8 for the largest nominal period.
  localparam int PER_W     = 15;
  localparam int OUT_PER_W = 14;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] SECOND_MS         = 32'd1000;
  localparam logic [15:0] STORED_PERIOD_RST = 16'd8000;
  localparam logic [31:0] SAVE_INTERVAL_RST = 32'd3600000;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SECONDS = 2'd1,
    OP_SET_LEN = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STORED_PERIOD = 2'd0,
    REG_SAVE_INTERVAL = 2'd1
  } cfg_reg_t;

  // One classified item waiting in the queue.
  typedef struct packed {
    op_t              op;
    logic             first;   // no earlier seconds report seen
    logic [31:0]      ext_ms;  // external elapsed ms, modulo 2^32
    logic [PER_W-1:0] period;  // clamped requested period
  } dmt_entry_t;

  // Configuration write as seen by the back end.
  typedef struct packed {
    logic                 wr;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } dmt_cfg_wr_t;

  function automatic logic [PER_W-1:0] clamp_period(input logic [15:0] p,
                                                    input logic [PER_W-1:0] lo,
                                                    input logic [PER_W-1:0] hi);
    logic [PER_W-1:0] r;
    if (p < {1'b0, lo}) begin
      r = lo;
    end else if (p > {1'b0, hi}) begin
      r = hi;
    end else begin
      r = p[PER_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/dmt_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: input items, result items and configuration writes.
// Depends on nothing; payload widths follow the block's field list.
interface dmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] seconds_value;
  logic [15:0] new_period;

  modport source (output valid, operation, seconds_value, new_period, input ready);
  modport sink (input valid, operation, seconds_value, new_period, output ready);
endinterface

interface dmt_out_if;
  logic               valid;
  logic               ready;
  logic               ms_tick;
  logic [13:0]        period_now;
  logic signed [31:0] drift_ms;
  logic               save_request;

  modport source (output valid, ms_tick, period_now, drift_ms, save_request,
                  input ready);
  modport sink (input valid, ms_tick, period_now, drift_ms, save_request,
                output ready);
endinterface

interface dmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [31:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

[src/dmt_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input items, decodes them and precomputes the external
// elapsed milliseconds. Depends on dmt_pkg and dmt_in_if.
module dmt_front import dmt_pkg::*; #(
  parameter int NOMINAL_PERIOD = 8000
) (
  input  logic        clk,
  input  logic        rst_n,
  dmt_in_if.sink      in_ch,
  input  logic        q_full,
  output logic        q_push,
  output dmt_entry_t  q_data
);

  localparam logic [PER_W-1:0] PER_LO = PER_W'(NOMINAL_PERIOD - (NOMINAL_PERIOD >> 3));
  localparam logic [PER_W-1:0] PER_HI = PER_W'(NOMINAL_PERIOD + (NOMINAL_PERIOD >> 3));

  logic [31:0] last_seconds_r, last_seconds_nxt;
  logic [31:0] delta_s;
  op_t         op;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;
  assign op          = op_t'(in_ch.operation);

  always_comb begin
    delta_s          = in_ch.seconds_value - last_seconds_r;
    q_data.op        = op;
    q_data.first     = (last_seconds_r == 32'd0);
    q_data.ext_ms    = 32'(delta_s * SECOND_MS);
    q_data.period    = clamp_period(in_ch.new_period, PER_LO, PER_HI);
    last_seconds_nxt = last_seconds_r;
    if (q_push && op == OP_SECONDS) begin
      last_seconds_nxt = in_ch.seconds_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seconds_r <= '0;
    end else begin
      last_seconds_r <= last_seconds_nxt;
    end
  end

endmodule

[src/dmt_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue of classified items between front and back end.
// Depends on dmt_pkg.
module dmt_queue import dmt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dmt_entry_t push_data,
  input  logic       pop,
  output dmt_entry_t head,
  output logic       empty,
  output logic       full
);

  dmt_entry_t  slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/dmt_back.sv]
`timescale 1ns / 1ps
// Back end: holds the timing state, executes queued items and drives the
// registered result channel. Depends on dmt_pkg and dmt_out_if.
module dmt_back import dmt_pkg::*; #(
  parameter int NOMINAL_PERIOD = 8000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dmt_entry_t  head,
  input  logic        q_empty,
  output logic        q_pop,
  input  dmt_cfg_wr_t cfg_wr,
  dmt_out_if.source   out_ch
);

  localparam logic [PER_W-1:0] PER_LO = PER_W'(NOMINAL_PERIOD - (NOMINAL_PERIOD >> 3));
  localparam logic [PER_W-1:0] PER_HI = PER_W'(NOMINAL_PERIOD + (NOMINAL_PERIOD >> 3));

  logic [PER_W-1:0] period_r, period_nxt;
  logic [PER_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [31:0]      ms_cnt_r, ms_cnt_nxt;
  logic [31:0]      ms_at_save_r, ms_at_save_nxt;
  logic [31:0]      last_ms_r, last_ms_nxt;
  logic [31:0]      drift_r, drift_nxt;
  logic [31:0]      save_int_r, save_int_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_tick_r, out_save_r;

  logic             tick;
  logic             save;
  logic [31:0]      int_ms;
  logic [31:0]      drift_calc;
  logic [15:0]      period_trim;
  logic             save_due;

  assign q_pop = !q_empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    period_nxt     = period_r;
    tick_cnt_nxt   = tick_cnt_r;
    ms_cnt_nxt     = ms_cnt_r;
    ms_at_save_nxt = ms_at_save_r;
    last_ms_nxt    = last_ms_r;
    drift_nxt      = drift_r;
    save_int_nxt   = save_int_r;
    tick           = 1'b0;
    save           = 1'b0;

    int_ms      = ms_cnt_r - last_ms_r;
    drift_calc  = head.ext_ms - int_ms;
    // Negative drift means the internal count runs fast: lengthen the period.
    period_trim = drift_calc[31] ? ({1'b0, period_r} + 16'd1)
                                 : ({1'b0, period_r} - 16'd1);
    save_due    = ms_cnt_r > (ms_at_save_r + save_int_r);

    if (q_pop) begin
      case (head.op)
        OP_TICK: begin
          if (tick_cnt_r >= period_r) begin
            tick         = 1'b1;
            tick_cnt_nxt = '0;
            ms_cnt_nxt   = ms_cnt_r + 32'd1;
          end else begin
            tick_cnt_nxt = tick_cnt_r + PER_W'(1);
          end
        end
        OP_SECONDS: begin
          if (!head.first) begin
            drift_nxt = drift_calc;
            if (drift_calc != 32'd0) begin
              period_nxt = clamp_period(period_trim, PER_LO, PER_HI);
              if (save_due) begin
                save           = 1'b1;
                ms_at_save_nxt = ms_cnt_r;
              end
            end
          end
          last_ms_nxt = ms_cnt_r;
        end
        OP_SET_LEN: begin
          period_nxt     = head.period;
          ms_at_save_nxt = ms_cnt_r;
          save           = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (cfg_wr.wr) begin
      case (cfg_reg_t'(cfg_wr.idx))
        REG_STORED_PERIOD: period_nxt   = clamp_period(cfg_wr.data[15:0], PER_LO, PER_HI);
        REG_SAVE_INTERVAL: save_int_nxt = cfg_wr.data;
        default: begin
        end
      endcase
    end

    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= clamp_period(STORED_PERIOD_RST, PER_LO, PER_HI);
      tick_cnt_r   <= '0;
      ms_cnt_r     <= '0;
      ms_at_save_r <= '0;
      last_ms_r    <= '0;
      drift_r      <= '0;
      save_int_r   <= SAVE_INTERVAL_RST;
      out_valid_r  <= 1'b0;
    end else begin
      period_r     <= period_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      ms_cnt_r     <= ms_cnt_nxt;
      ms_at_save_r <= ms_at_save_nxt;
      last_ms_r    <= last_ms_nxt;
      drift_r      <= drift_nxt;
      save_int_r   <= save_int_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload registers load only when a new item completes.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_tick_r <= tick;
      out_save_r <= save;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ms_tick      = out_tick_r;
  assign out_ch.save_request = out_save_r;
  // Period and drift reflect the state after the last completed item.
  assign out_ch.period_now   = period_r[OUT_PER_W-1:0];
  assign out_ch.drift_ms     = signed'(drift_r);

endmodule

[src/disciplined_ms_tick_generator.sv]
`timescale 1ns / 1ps
// Top level of the disciplined millisecond tick generator.
// Depends on dmt_pkg, dmt_if, dmt_front, dmt_queue and dmt_back.
//
// Usage:
//   in_ch   - one transaction per item: operation (tick, seconds report,
//             set period), seconds_value and new_period.
//   out_ch  - exactly one result transaction per input item, in order:
//             ms_tick, period_now, drift_ms and save_request.
//   cfg_ch  - register writes (idx 0 stored period, idx 1 save interval);
//             always ready, write only while no item is in flight.
//   Path: an accepted item is written into the queue, then the back end
//   pops it and loads the output register; the result is held there until
//   out_ch takes it.
//   Throughput: one item per cycle while out_ch is ready; the back end
//   updates all timing state on each pop, so clock ticks stream back to back.
//   Stall: if out_ch is held off, the two-entry queue absorbs the items in
//   flight and in_ch.ready drops once it is full; nothing is lost.
//   Reset (rst_n low, synchronous): the period loads the clamped stored
//   period reset value, all counters and the drift clear, the queue empties
//   and out_ch.valid drops.
module disciplined_ms_tick_generator import dmt_pkg::*; #(
  parameter int NOMINAL_PERIOD = 8000
) (
  input  logic       clk,
  input  logic       rst_n,
  dmt_in_if.sink     in_ch,
  dmt_out_if.source  out_ch,
  dmt_cfg_if.sink    cfg_ch
);

  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  dmt_entry_t  q_wdata;
  dmt_entry_t  q_head;
  dmt_cfg_wr_t cfg_wr;

  // Configuration writes go straight to the back end registers; never back-pressure it.
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.wr    = cfg_ch.valid;
  assign cfg_wr.idx   = cfg_ch.idx;
  assign cfg_wr.data  = cfg_ch.data;

  // Front end: decode, clamp requested period, compute external elapsed ms.
  dmt_front #(
    .NOMINAL_PERIOD(NOMINAL_PERIOD)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // Decouple front and back so either side can stall independently.
  dmt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back end: advance tick counter, trim the period, raise save requests.
  dmt_back #(
    .NOMINAL_PERIOD(NOMINAL_PERIOD)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .cfg_wr  (cfg_wr),
    .out_ch  (out_ch)
  );

endmodule

[src/dmt_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the tick generator, bound to the top level.
// Depends on dmt_pkg for widths.
module dmt_checker import dmt_pkg::*; #(
  parameter int NOMINAL_PERIOD = 8000
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_tick,
  input logic               out_save,
  input logic [13:0]        out_period,
  input logic signed [31:0] out_drift
);

  localparam int PER_LO  = NOMINAL_PERIOD - (NOMINAL_PERIOD >> 3);
  localparam int PER_HI  = NOMINAL_PERIOD + (NOMINAL_PERIOD >> 3);
  localparam bit HI_FITS = (PER_HI < (1 << OUT_PER_W));
  localparam logic [13:0] LO14 = 14'(PER_LO);
  localparam logic [13:0] HI14 = 14'(PER_HI);

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_period)
      && $stable(out_drift) && $stable(out_tick) && $stable(out_save))
    else $error("stalled result changed");

  // Drop the result channel during reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Keep the reported period inside the trim window.
  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && HI_FITS |-> out_period >= LO14 && out_period <= HI14)
    else $error("period outside trim window");

  // A millisecond tick never comes with a save request.
  a_tick_no_save: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tick && out_save))
    else $error("tick and save request together");

endmodule

bind disciplined_ms_tick_generator dmt_checker #(
  .NOMINAL_PERIOD(NOMINAL_PERIOD)
) u_dmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_tick   (out_ch.ms_tick),
  .out_save   (out_ch.save_request),
  .out_period (out_ch.period_now),
  .out_drift  (out_ch.drift_ms)
);
